// File: rtl/assert_macros.svh
// Assertion macros shared by the window generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CSW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CSW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CSW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CSW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/csw_pkg.sv
// Types, constants and coefficient tables for the cosine-sum window generator.
package csw_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int FRAC_BITS  = 16;

  localparam int LEN_W    = 13;
  localparam int KIND_W   = 3;
  localparam int IDX_W    = 12;
  localparam int COEF_W   = 18;
  localparam int D_W      = 13;
  localparam int PH_W     = 32;
  localparam int LANES    = 4;
  localparam int DIV_STAGES = 4;
  localparam int DIV_BITS = PH_W / DIV_STAGES;
  localparam int COS_STAGES = 9;
  localparam int SHIFT    = 60 - FRAC_BITS;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [1:0] REG_LENGTH   = 2'd0;
  localparam logic [1:0] REG_KIND     = 2'd1;
  localparam logic [1:0] REG_PERIODIC = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE =
    (FRAC_BITS >= COEF_W - 1) ? COEF_MAX : COEF_W'(64'sd1 <<< FRAC_BITS);

  // cos(pi*t/2) Horner constants, Q30: CC6 seeds, then CC5..CC1, then 1.0
  localparam logic [30:0] HORNER_SEED = 31'd506;
  localparam logic [30:0] HORNER_C [6] = '{
    31'd27061, 31'd987048, 31'd22401992, 31'd272375560, 31'd1324675879, 31'd1073741824
  };

  // a0..a4 per window kind, Q30
  localparam logic [29:0] KIND_TAB [8][5] = '{
    '{30'd579820585, 30'd493921239, 30'd0, 30'd0, 30'd0},
    '{30'd536870912, 30'd536870912, 30'd0, 30'd0, 30'd0},
    '{30'd450971566, 30'd536870912, 30'd85899346, 30'd0, 30'd0},
    '{30'd231476135, 30'd447354753, 30'd297709049, 30'd89742211, 30'd7459680},
    '{30'd390393092, 30'd525250341, 30'd146672596, 30'd11425794, 30'd0},
    '{30'd385204879, 30'd524297395, 30'd151698245, 30'd12541305, 30'd0},
    '{30'd0, 30'd0, 30'd0, 30'd0, 30'd0},
    '{30'd0, 30'd0, 30'd0, 30'd0, 30'd0}
  };

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [KIND_W-1:0] kind;
    logic              periodic;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              err;
    logic              dz;
    logic [KIND_W-1:0] kind;
  } side_t;

endpackage

// File: rtl/csw_if.sv
// Request and response channel interfaces of the window generator.
interface csw_req_if;
  import csw_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;
  modport source (output valid, sample_index, input ready);
  modport sink (input valid, sample_index, output ready);
endinterface

interface csw_rsp_if;
  import csw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient;
  logic                     index_error;
  modport source (output valid, coefficient, index_error, input ready);
  modport sink (input valid, coefficient, index_error, output ready);
endinterface

// File: rtl/csw_regs.sv
// APB configuration registers of the window generator.
module csw_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csw_pkg::ADDR_W-1:0] paddr,
  input  logic [csw_pkg::DATA_W-1:0] pwdata,
  output logic [csw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output csw_pkg::cfg_t              cfg
);
  import csw_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length   <= LEN_RESET;
      cfg.kind     <= '0;
      cfg.periodic <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_LENGTH:   cfg.length   <= pwdata[LEN_W-1:0];
        REG_KIND:     cfg.kind     <= pwdata[KIND_W-1:0];
        REG_PERIODIC: cfg.periodic <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LENGTH:   prdata = DATA_W'(cfg.length);
      REG_KIND:     prdata = DATA_W'(cfg.kind);
      REG_PERIODIC: prdata = DATA_W'(cfg.periodic);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/csw_phase.sv
// Range check, harmonic residues and pipelined phase division for four lanes.
module csw_phase (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [csw_pkg::IDX_W-1:0] in_index,
  input  csw_pkg::cfg_t             cfg,
  output csw_pkg::side_t            side,
  output logic [csw_pkg::PH_W-1:0]  phase [csw_pkg::LANES]
);
  import csw_pkg::*;

  function automatic logic [D_W-1:0] modred(input logic [D_W:0] x, input logic [D_W-1:0] d);
    modred = (x >= {1'b0, d}) ? D_W'(x - {1'b0, d}) : D_W'(x);
  endfunction

  // accept stage
  side_t            s0_side;
  logic [IDX_W-1:0] s0_index;
  logic [D_W-1:0]   s0_d;
  logic [LEN_W-1:0] n_eff;

  always_comb begin
    n_eff = (int'(cfg.length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : cfg.length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_side <= '0;
    end else if (ce) begin
      s0_side.valid <= in_valid;
      s0_side.err   <= {1'b0, in_index} >= n_eff;
      s0_side.dz    <= (cfg.periodic ? n_eff : n_eff - LEN_W'(1)) == '0;
      s0_side.kind  <= cfg.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_index <= in_index;
      s0_d     <= cfg.periodic ? n_eff : n_eff - LEN_W'(1);
    end
  end

  // residue stage: (k*i) mod D, then division stages
  side_t          st_side [DIV_STAGES+1];
  logic [D_W-1:0] st_d    [DIV_STAGES+1];
  logic [D_W-1:0] st_rem  [DIV_STAGES+1][LANES];
  logic [PH_W-1:0] st_q   [DIV_STAGES+1][LANES];
  logic [D_W-1:0] r [LANES];

  always_comb begin
    r[0] = modred({1'b0, D_W'(s0_index)}, s0_d);
    r[1] = modred({r[0], 1'b0}, s0_d);
    r[2] = modred({1'b0, r[1]} + {1'b0, r[0]}, s0_d);
    r[3] = modred({r[1], 1'b0}, s0_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_side[0] <= '0;
    end else if (ce) begin
      st_side[0] <= s0_side;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st_d[0] <= s0_d;
      for (int l = 0; l < LANES; l++) begin
        st_rem[0][l] <= r[l];
        st_q[0][l]   <= '0;
      end
    end
  end

  // long division of r*2^32 + floor(D/2) by D, DIV_BITS quotient bits a stage
  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [D_W-1:0]  rem_n [LANES];
    logic [PH_W-1:0] q_n   [LANES];

    always_comb begin
      logic [PH_W-1:0] h32;
      logic [D_W-1:0]  rem_t;
      logic [PH_W-1:0] q_t;
      logic [D_W:0]    ext;
      int              j;
      h32 = PH_W'(st_d[s-1] >> 1);
      for (int l = 0; l < LANES; l++) begin
        rem_t = st_rem[s-1][l];
        q_t   = st_q[s-1][l];
        for (int b = 0; b < DIV_BITS; b++) begin
          j   = PH_W - 1 - (s - 1) * DIV_BITS - b;
          ext = {rem_t, h32[j]};
          if (ext >= {1'b0, st_d[s-1]}) begin
            rem_t  = D_W'(ext - {1'b0, st_d[s-1]});
            q_t[j] = 1'b1;
          end else begin
            rem_t = D_W'(ext);
          end
        end
        rem_n[l] = rem_t;
        q_n[l]   = q_t;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_side[s] <= '0;
      end else if (ce) begin
        st_side[s] <= st_side[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_d[s] <= st_d[s-1];
        for (int l = 0; l < LANES; l++) begin
          st_rem[s][l] <= rem_n[l];
          st_q[s][l]   <= q_n[l];
        end
      end
    end
  end

  assign side = st_side[DIV_STAGES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      phase[l] = st_q[DIV_STAGES][l];
    end
  end

endmodule

// File: rtl/csw_cos.sv
// Pipelined cosine of a phase in turns: quadrant fold, square, Horner chain.
module csw_cos (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [csw_pkg::PH_W-1:0]  phase,
  output logic signed [31:0]        cos_q30
);
  import csw_pkg::*;

  logic [30:0] fa;
  logic        fa_neg;
  logic [30:0] ub;
  logic        ub_neg;
  logic [61:0] sq;

  // fold into first quadrant; q1, q2 negate, q1, q3 mirror
  always_ff @(posedge clk) begin
    if (ce) begin
      fa     <= phase[30] ? (31'd1 << 30) - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
      fa_neg <= phase[31] ^ phase[30];
    end
  end

  assign sq = {31'd0, fa} * {31'd0, fa};

  always_ff @(posedge clk) begin
    if (ce) begin
      ub     <= sq[60:30];
      ub_neg <= fa_neg;
    end
  end

  logic [30:0]        hu   [6];
  logic signed [32:0] hp   [6];
  logic               hneg [6];

  for (genvar k = 0; k < 6; k++) begin : g_horner
    logic [30:0] u_in;
    logic [30:0] p_in;
    logic        n_in;
    logic [61:0] prod;

    if (k == 0) begin : g_first
      assign u_in = ub;
      assign p_in = HORNER_SEED;
      assign n_in = ub_neg;
    end else begin : g_next
      assign u_in = hu[k-1];
      assign p_in = hp[k-1][30:0];
      assign n_in = hneg[k-1];
    end

    assign prod = {31'd0, u_in} * {31'd0, p_in};

    always_ff @(posedge clk) begin
      if (ce) begin
        hu[k]   <= u_in;
        hp[k]   <= $signed({2'b00, HORNER_C[k]}) - $signed({1'b0, prod[61:30]});
        hneg[k] <= n_in;
      end
    end
  end

  logic signed [32:0] clamped;

  always_comb begin
    if (hp[5] < 0) begin
      clamped = '0;
    end else if (hp[5] > 33'sd1073741824) begin
      clamped = 33'sd1073741824;
    end else begin
      clamped = hp[5];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cos_q30 <= hneg[5] ? 32'(-clamped) : 32'(clamped);
    end
  end

endmodule

// File: rtl/csw_sum.sv
// Weighted harmonic sum, rounding, saturation and output register.
module csw_sum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ce,
  input  csw_pkg::side_t                    side_in,
  input  logic signed [31:0]                cos_in [csw_pkg::LANES],
  output logic                              out_valid,
  output logic signed [csw_pkg::COEF_W-1:0] coefficient,
  output logic                              index_error
);
  import csw_pkg::*;

  side_t              t_side;
  logic [29:0]        t_a0;
  logic signed [62:0] t_term [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_side <= '0;
    end else if (ce) begin
      t_side <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t_a0 <= KIND_TAB[side_in.kind][0];
      for (int k = 0; k < LANES; k++) begin
        t_term[k] <= $signed({1'b0, KIND_TAB[side_in.kind][k+1]}) * cos_in[k];
      end
    end
  end

  side_t              s_side;
  logic signed [63:0] s_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_side <= '0;
    end else if (ce) begin
      s_side <= t_side;
    end
  end

  // odd harmonics subtract, even ones add
  always_ff @(posedge clk) begin
    if (ce) begin
      s_sum <= $signed({4'd0, t_a0, 30'd0}) - 64'(t_term[0]) + 64'(t_term[1])
             - 64'(t_term[2]) + 64'(t_term[3]);
    end
  end

  logic signed [63:0]       rnd;
  logic signed [63:0]       shifted;
  logic signed [COEF_W-1:0] sat;

  always_comb begin
    rnd     = s_sum + (64'sd1 <<< (SHIFT - 1));
    shifted = rnd >>> SHIFT;
    if (shifted > 64'(COEF_MAX)) begin
      sat = COEF_MAX;
    end else if (shifted < 64'(COEF_MIN)) begin
      sat = COEF_MIN;
    end else begin
      sat = COEF_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= s_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      index_error <= s_side.err;
      if (s_side.err) begin
        coefficient <= '0;
      end else if (s_side.dz) begin
        coefficient <= COEF_ONE;
      end else begin
        coefficient <= sat;
      end
    end
  end

endmodule

// File: rtl/cosine_sum_window_generator_unit.sv
// Top level of the cosine-sum window coefficient generator.
// Pipeline from the request transfer to the response becoming valid:
//   6 phase stages, 9 cosine stages, 3 sum/output stages.
// Throughput: one index per cycle; back-pressure on the response freezes
//   the whole pipeline, so nothing is dropped or repeated.
// Reset (rst, synchronous): clears pipeline valids; length 1024, Hamming, symmetric.
`include "assert_macros.svh"
module cosine_sum_window_generator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [csw_pkg::ADDR_W-1:0] paddr,
  input  logic [csw_pkg::DATA_W-1:0] pwdata,
  output logic [csw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  csw_req_if.sink                    req,
  csw_rsp_if.source                  rsp
);
  import csw_pkg::*;

  cfg_t cfg;
  logic ce;

  // pipeline advances unless a finished result sits unaccepted
  assign ce        = !rsp.valid || rsp.ready;
  assign req.ready = ce;

  csw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  side_t             ph_side;
  logic [PH_W-1:0]   ph [LANES];

  // index check, (k*i) mod D and the phase division
  csw_phase u_phase (
    .clk      (clk),
    .rst      (rst),
    .ce       (ce),
    .in_valid (req.valid),
    .in_index (req.sample_index),
    .cfg      (cfg),
    .side     (ph_side),
    .phase    (ph)
  );

  logic signed [31:0] cosv [LANES];

  // one cosine pipe per harmonic
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    csw_cos u_cos (
      .clk     (clk),
      .ce      (ce),
      .phase   (ph[l]),
      .cos_q30 (cosv[l])
    );
  end

  // side information delayed alongside the cosine pipes
  side_t side_d [COS_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < COS_STAGES; k++) begin
        side_d[k] <= '0;
      end
    end else if (ce) begin
      side_d[0] <= ph_side;
      for (int k = 1; k < COS_STAGES; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  csw_sum u_sum (
    .clk         (clk),
    .rst         (rst),
    .ce          (ce),
    .side_in     (side_d[COS_STAGES-1]),
    .cos_in      (cosv),
    .out_valid   (rsp.valid),
    .coefficient (rsp.coefficient),
    .index_error (rsp.index_error)
  );

  `CSW_ASSERT_IMP(a_err_zero, clk, rst, rsp.valid && rsp.index_error, rsp.coefficient == '0, "index error with nonzero coefficient")
  `CSW_ASSERT_IMP(a_stall_src, clk, rst, !req.ready, rsp.valid && !rsp.ready, "request stalled without response back-pressure")
  `CSW_ASSERT_IMP(a_rise_ce, clk, rst, $rose(rsp.valid), $past(ce), "response appeared while pipeline frozen")
  `CSW_ASSERT_NXT(a_kind_wr, clk, rst, psel && penable && pwrite && paddr[3:2] == REG_KIND, cfg.kind == $past(pwdata[KIND_W-1:0]), "window kind write lost")

endmodule
